@@ design/eds_pkg.sv @@
package eds_pkg;

  // Widths of the fixed input and result fields.
  localparam int SLOT_W  = 5;
  localparam int DELAY_W = 31;
  localparam int CYC_W   = 32;

  // Shared arithmetic unit operations.
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // Command codes.
  localparam logic CMD_SCHEDULE = 1'b0;
  localparam logic CMD_TEST     = 1'b1;

  // Result kinds.
  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // Test walk over the fixed slot list.
  localparam int VISIT_IDX_W = 4;
  localparam logic [VISIT_IDX_W-1:0] VISIT_LAST = 4'd9;

  // Compare flags from the shared unit.
  typedef struct packed {
    logic ge_s;  // difference, taken as signed, is at least the delay
    logic gt_s;  // difference, taken as signed, exceeds the delay
    logic gt_u;  // difference, taken as unsigned, exceeds the delay
  } eds_flags_t;

  // Slot visited at each step of a test.
  function automatic logic [SLOT_W-1:0] visit_slot(input logic [VISIT_IDX_W-1:0] idx);
    logic [SLOT_W-1:0] s;
    unique case (idx)
      4'd0:    s = 5'd9;
      4'd1:    s = 5'd10;
      4'd2:    s = 5'd16;
      4'd3:    s = 5'd19;
      4'd4:    s = 5'd17;
      4'd5:    s = 5'd18;
      4'd6:    s = 5'd11;
      4'd7:    s = 5'd12;
      4'd8:    s = 5'd20;
      4'd9:    s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage

@@ design/eds_slot_mem.sv @@
module eds_slot_mem import eds_pkg::*; #(
  parameter int NUM_SLOTS = 32,
  parameter int AW = $clog2(NUM_SLOTS)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [CYC_W-1:0]   wr_start,
  input  logic [DELAY_W-1:0] wr_delay,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [CYC_W-1:0]   rd_start,
  output logic [DELAY_W-1:0] rd_delay
);

  logic [CYC_W+DELAY_W-1:0] mem [NUM_SLOTS];
  logic [CYC_W+DELAY_W-1:0] rd_data_r;

  // One write port, taken when a slot is scheduled.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_start, wr_delay};
    end
  end

  // One registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_start = rd_data_r[CYC_W+DELAY_W-1:DELAY_W];
  assign rd_delay = rd_data_r[DELAY_W-1:0];

endmodule

@@ design/eds_cmp_unit.sv @@
module eds_cmp_unit import eds_pkg::*; (
  input  logic               op,
  input  logic [CYC_W-1:0]   a,
  input  logic [CYC_W-1:0]   b,
  input  logic [DELAY_W-1:0] d,
  output logic [CYC_W-1:0]   sum,
  output eds_flags_t         flags
);

  // One wrapping adder, inverting b for a subtract.
  always_comb begin
    if (op == OP_SUB) begin
      sum = a + ~b + 32'd1;
    end else begin
      sum = a + b;
    end
  end

  // The delay is never negative, so a negative difference never reaches it.
  always_comb begin
    flags.ge_s = !sum[CYC_W-1] && (sum[DELAY_W-1:0] >= d);
    flags.gt_s = !sum[CYC_W-1] && (sum[DELAY_W-1:0] > d);
    flags.gt_u = sum[CYC_W-1] || (sum[DELAY_W-1:0] > d);
  end

endmodule

@@ design/event_deadline_scheduler_core.sv @@
// Event deadline scheduler core.
// Input channel: a command is transferred at a rising edge with start high and
// busy low. A schedule command arms in_slot with in_now_cycle and in_delay and
// may pull the earliest deadline in; a slot at or above NUM_SLOTS is ignored.
// A test command loads in_counter_deadline as the deadline, then walks slots
// 9, 10, 16, 19, 17, 18, 11, 12, 20 and 21.
// Result channel: out_valid is high for exactly one cycle per result. Each
// visited pending slot that is due gives a fired result; the test ends with
// one deadline report carrying out_last. The receiver cannot stall the block.
// Operation: all slot arithmetic goes through one shared adder and compare
// unit; slot data comes from a memory with one write port and a registered
// read port. A schedule keeps busy high for a compare step and, when the new
// deadline is sooner, an add step; busy stays low when its slot is ignored. A
// test reads each visited slot, checks a pending one for due or pull-in, then
// reports; each result appears in the cycle after the step that produced it.
// Reset clears the pending set, the deadline and the sequencer; slot memory
// is not cleared, since only pending slots are ever read.
module event_deadline_scheduler_core import eds_pkg::*; #(
  parameter int NUM_SLOTS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_command,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic [DELAY_W-1:0] in_delay,
  input  logic [CYC_W-1:0]   in_now_cycle,
  input  logic [CYC_W-1:0]   in_counter_deadline,
  output logic               out_valid,
  output logic               out_kind,
  output logic [SLOT_W-1:0]  out_fired_slot,
  output logic [CYC_W-1:0]   out_next_deadline,
  output logic               out_last
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W+1)'(NUM_SLOTS);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_SCHED_CMP = 3'd1;
  localparam logic [2:0] ST_SCHED_ADD = 3'd2;
  localparam logic [2:0] ST_READ      = 3'd3;
  localparam logic [2:0] ST_DUE       = 3'd4;
  localparam logic [2:0] ST_GAP       = 3'd5;
  localparam logic [2:0] ST_PULL      = 3'd6;
  localparam logic [2:0] ST_REPORT    = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic [NUM_SLOTS-1:0]   pend_r, pend_nxt;
  logic [CYC_W-1:0]       ed_r, ed_nxt;
  logic [CYC_W-1:0]       now_r, now_nxt;
  logic [DELAY_W-1:0]     delay_r, delay_nxt;
  logic [VISIT_IDX_W-1:0] idx_r, idx_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]      out_slot_r, out_slot_nxt;
  logic [CYC_W-1:0]       out_dl_r, out_dl_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   in_range;
  logic                   mem_we;
  logic                   rd_en;
  logic [SLOT_W-1:0]      cur_slot;
  logic [CYC_W-1:0]       rd_start;
  logic [DELAY_W-1:0]     rd_delay;

  logic                   u_op;
  logic [CYC_W-1:0]       u_a, u_b, u_sum;
  logic [DELAY_W-1:0]     u_d;
  eds_flags_t             u_flags;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, in_slot} < SLOT_LIMIT);
  assign mem_we   = accept && (in_command == CMD_SCHEDULE) && in_range;
  assign cur_slot = visit_slot(idx_r);

  eds_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .AW        (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (in_slot[AW-1:0]),
    .wr_start (in_now_cycle),
    .wr_delay (in_delay),
    .rd_en    (rd_en),
    .rd_addr  (cur_slot[AW-1:0]),
    .rd_start (rd_start),
    .rd_delay (rd_delay)
  );

  eds_cmp_unit u_cmp (
    .op    (u_op),
    .a     (u_a),
    .b     (u_b),
    .d     (u_d),
    .sum   (u_sum),
    .flags (u_flags)
  );

  // Operand selection for the shared unit.
  always_comb begin
    u_op = OP_SUB;
    u_a  = ed_r;
    u_b  = now_r;
    u_d  = delay_r;
    unique case (state_r)
      ST_SCHED_ADD: begin
        u_op = OP_ADD;
        u_a  = now_r;
        u_b  = {1'b0, delay_r};
      end
      ST_DUE: begin
        u_a = now_r;
        u_b = rd_start;
        u_d = rd_delay;
      end
      ST_GAP: begin
        u_b = rd_start;
        u_d = rd_delay;
      end
      ST_PULL: begin
        u_op = OP_ADD;
        u_a  = rd_start;
        u_b  = {1'b0, rd_delay};
      end
      default: begin
      end
    endcase
  end

  // Sequencer for schedule and test commands.
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    ed_nxt        = ed_r;
    now_nxt       = now_r;
    delay_nxt     = delay_r;
    idx_nxt       = idx_r;
    rd_en         = 1'b0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_dl_nxt    = out_dl_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          now_nxt   = in_now_cycle;
          delay_nxt = in_delay;
          if (in_command == CMD_TEST) begin
            ed_nxt    = in_counter_deadline;
            idx_nxt   = '0;
            state_nxt = ST_READ;
          end else if (in_range) begin
            pend_nxt[in_slot[AW-1:0]] = 1'b1;
            state_nxt = ST_SCHED_CMP;
          end
        end
      end
      ST_SCHED_CMP: begin
        state_nxt = u_flags.gt_u ? ST_SCHED_ADD : ST_IDLE;
      end
      ST_SCHED_ADD: begin
        ed_nxt    = u_sum;
        state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (pend_r[cur_slot[AW-1:0]]) begin
          rd_en     = 1'b1;
          state_nxt = ST_DUE;
        end else if (idx_r == VISIT_LAST) begin
          state_nxt = ST_REPORT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_DUE: begin
        if (u_flags.ge_s) begin
          pend_nxt[cur_slot[AW-1:0]] = 1'b0;
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FIRED;
          out_slot_nxt  = cur_slot;
          out_dl_nxt    = '0;
          out_last_nxt  = 1'b0;
          if (idx_r == VISIT_LAST) begin
            state_nxt = ST_REPORT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_READ;
          end
        end else begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP: begin
        if (u_flags.gt_s) begin
          state_nxt = ST_PULL;
        end else if (idx_r == VISIT_LAST) begin
          state_nxt = ST_REPORT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_PULL: begin
        ed_nxt = u_sum;
        if (idx_r == VISIT_LAST) begin
          state_nxt = ST_REPORT;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_REPORT: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = KIND_REPORT;
        out_slot_nxt  = '0;
        out_dl_nxt    = ed_r;
        out_last_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      ed_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      ed_r        <= ed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    now_r      <= now_nxt;
    delay_r    <= delay_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_dl_r   <= out_dl_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_fired_slot    = out_slot_r;
  assign out_next_deadline = out_dl_r;
  assign out_last          = out_last_r;

  // Only the deadline report closes a test.
  a_last_on_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == out_last))
    else $error("last flag does not match result kind");

  // A test transfer always starts the slot walk.
  a_test_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_command == CMD_TEST)) |=> busy)
    else $error("test command did not start");

  // Results come only from the due check or the report step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_DUE || $past(state_r) == ST_REPORT))
    else $error("result strobe from an unexpected step");

  // A fired slot is no longer pending.
  a_fired_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_FIRED)) |-> !pend_r[out_fired_slot[AW-1:0]])
    else $error("fired slot still pending");

endmodule

@@ bench/event_deadline_scheduler_core_test.sv @@
`timescale 1ns / 100ps

module event_deadline_scheduler_core_test;
  import eds_pkg::*;

  localparam int NUM_SLOTS     = 32;
  localparam int VISITS        = 10;
  localparam int SETTLE_CYCLES = 50;
  localparam int REPORT_LIMIT  = 10;
  localparam int MAX_GAP       = 40;
  localparam int RUN_LIMIT_NS  = 5_000_000;

  // Slots walked by a test command, first visit in the low bits.
  localparam logic [VISITS*SLOT_W-1:0] WALK_ORDER = {
    5'd21, 5'd20, 5'd12, 5'd11, 5'd18, 5'd17, 5'd19, 5'd16, 5'd10, 5'd9
  };

  // One result as it appears on the out_ ports.
  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [CYC_W-1:0]  deadline;
    logic              last;
  } sched_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_command = CMD_SCHEDULE;
  logic [SLOT_W-1:0]  in_slot = '0;
  logic [DELAY_W-1:0] in_delay = '0;
  logic [CYC_W-1:0]   in_now_cycle = '0;
  logic [CYC_W-1:0]   in_counter_deadline = '0;
  logic               out_valid;
  logic               out_kind;
  logic [SLOT_W-1:0]  out_fired_slot;
  logic [CYC_W-1:0]   out_next_deadline;
  logic               out_last;

  // Scheduler state as the bench expects it to be.
  logic [NUM_SLOTS-1:0] armed_slots;
  logic [CYC_W-1:0]     slot_start [NUM_SLOTS];
  logic [CYC_W-1:0]     slot_delay [NUM_SLOTS];
  logic [CYC_W-1:0]     model_deadline;

  sched_result_t predicted_results [$];
  int                   mismatches = 0;
  int                   idle_pct = 0;
  logic [CYC_W-1:0]     sim_cycle = '0;

  event_deadline_scheduler_core #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_slot             (in_slot),
    .in_delay            (in_delay),
    .in_now_cycle        (in_now_cycle),
    .in_counter_deadline (in_counter_deadline),
    .out_valid           (out_valid),
    .out_kind            (out_kind),
    .out_fired_slot      (out_fired_slot),
    .out_next_deadline   (out_next_deadline),
    .out_last            (out_last)
  );

  always #5 clk = ~clk;

  // Update the expected state for one accepted command and queue its results.
  task automatic apply_command(input logic cmd, input logic [SLOT_W-1:0] slot,
                               input logic [DELAY_W-1:0] dly,
                               input logic [CYC_W-1:0] now,
                               input logic [CYC_W-1:0] counter);
    int                      i;
    logic [SLOT_W-1:0]       s;
    logic [CYC_W-1:0]        ahead;
    logic signed [CYC_W-1:0] elapsed;
    logic signed [CYC_W-1:0] gap;
    logic signed [CYC_W-1:0] wait_len;
    sched_result_t           r;
    if (cmd == CMD_SCHEDULE) begin
      if (int'(slot) < NUM_SLOTS) begin
        armed_slots[slot] = 1'b1;
        slot_start[slot]  = now;
        slot_delay[slot]  = {1'b0, dly};
        // Unsigned wrapping distance decides whether the new deadline is sooner.
        ahead = model_deadline - now;
        if (ahead > {1'b0, dly}) begin
          model_deadline = now + {1'b0, dly};
        end
      end
    end else begin
      model_deadline = counter;
      for (i = 0; i < VISITS; i++) begin
        s = WALK_ORDER[i*SLOT_W +: SLOT_W];
        if (int'(s) < NUM_SLOTS && armed_slots[s]) begin
          elapsed  = now - slot_start[s];
          wait_len = slot_delay[s];
          if (elapsed >= wait_len) begin
            armed_slots[s] = 1'b0;
            r.kind     = KIND_FIRED;
            r.slot     = s;
            r.deadline = '0;
            r.last     = 1'b0;
            predicted_results.push_back(r);
          end else begin
            gap = model_deadline - slot_start[s];
            if (gap > wait_len) begin
              model_deadline = slot_start[s] + slot_delay[s];
            end
          end
        end
      end
      r.kind     = KIND_REPORT;
      r.slot     = '0;
      r.deadline = model_deadline;
      r.last     = 1'b1;
      predicted_results.push_back(r);
    end
  endtask

  // Drive one command at the falling edge and hold it until the transfer.
  task automatic send_command(input logic cmd, input logic [SLOT_W-1:0] slot,
                              input logic [DELAY_W-1:0] dly,
                              input logic [CYC_W-1:0] now,
                              input logic [CYC_W-1:0] counter);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_command          = cmd;
    in_slot             = slot;
    in_delay            = dly;
    in_now_cycle        = now;
    in_counter_deadline = counter;
    start               = 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    apply_command(cmd, slot, dly, now, counter);
    @(negedge clk);
  endtask

  // Hold off the sender until every queued result has come out.
  task automatic drain_results();
    start = 1'b0;
    while (predicted_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // A test with nothing pending reports the counter deadline unchanged.
  task automatic test_empty_report();
    send_command(CMD_TEST, 5'd31, 31'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'hFFFF_FFFF, 32'h0000_0000);
  endtask

  // Every visited slot due at once gives the longest result train; slots
  // outside the walk stay pending and silent.
  task automatic test_fire_all_slots();
    int i;
    for (i = 0; i < VISITS; i++) begin
      send_command(CMD_SCHEDULE, WALK_ORDER[i*SLOT_W +: SLOT_W], 31'h0,
                   32'hFFFF_FFF0, 32'h0);
    end
    send_command(CMD_SCHEDULE, 5'd0, 31'h0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_command(CMD_SCHEDULE, 5'd31, 31'h0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'hFFFF_FFF0, 32'h1234_5678);
  endtask

  // A waiting slot pulls the deadline in, a start in the future is not due,
  // and a slot fires exactly when elapsed time equals its delay.
  task automatic test_pull_in_and_wrap();
    send_command(CMD_SCHEDULE, 5'd9, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_command(CMD_SCHEDULE, 5'd21, 31'd5, 32'd100, 32'h0);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'd50, 32'd1000);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'd105, 32'hFFFF_FFFF);
    // Largest delay reached exactly across the wrap of the cycle count.
    send_command(CMD_TEST, 5'd0, 31'h0, 32'h7FFF_FFFE, 32'h0);
  endtask

  // The most negative elapsed time is never due but still pulls in.
  task automatic test_signed_extremes();
    send_command(CMD_SCHEDULE, 5'd10, 31'h0, 32'h0, 32'h0);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'h8000_0000, 32'd1);
    send_command(CMD_TEST, 5'd0, 31'h0, 32'd1, 32'h8000_0000);
  endtask

  // Mostly schedules near the running cycle count followed by tests, with
  // some far jumps and arbitrary slots mixed in.
  task automatic test_random_traffic(input int pct, input int count);
    int                 n;
    int                 pick;
    logic [SLOT_W-1:0]  s;
    logic [DELAY_W-1:0] d;
    logic [CYC_W-1:0]   c;
    idle_pct = pct;
    for (n = 0; n < count; n++) begin
      pick      = $urandom_range(99);
      sim_cycle = sim_cycle + $urandom_range(30);
      s         = SLOT_W'($urandom());
      d         = DELAY_W'($urandom());
      c         = $urandom();
      if (pick < 50) begin
        s = WALK_ORDER[$urandom_range(VISITS - 1)*SLOT_W +: SLOT_W];
        if ($urandom_range(7) != 0) begin
          d = DELAY_W'($urandom_range(80));
        end
        send_command(CMD_SCHEDULE, s, d, sim_cycle, c);
      end else if (pick < 82) begin
        if ($urandom_range(3) != 0) begin
          c = sim_cycle + $urandom_range(400);
        end
        send_command(CMD_TEST, s, d, sim_cycle, c);
      end else if (pick < 92) begin
        send_command(CMD_SCHEDULE, s, d, $urandom(), c);
      end else begin
        send_command(CMD_TEST, s, d, $urandom(), c);
      end
    end
  endtask

  // Compare each result with the oldest expected one.
  always @(posedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst_n && out_valid) begin
      got.kind     = out_kind;
      got.slot     = out_fired_slot;
      got.deadline = out_next_deadline;
      got.last     = out_last;
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: unexpected result kind=%0b slot=%0d deadline=%h last=%0b",
                   $realtime, got.kind, got.slot, got.deadline, got.last);
        end
      end else begin
        want = predicted_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: expected kind=%0b slot=%0d deadline=%h last=%0b",
                     $realtime, want.kind, want.slot, want.deadline, want.last);
            $display("%0t:      got kind=%0b slot=%0d deadline=%h last=%0b",
                     $realtime, got.kind, got.slot, got.deadline, got.last);
          end
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #RUN_LIMIT_NS;
    $display("Mismatches found");
    $finish;
  end

  // Test sequence.
  initial begin
    int i;
    armed_slots    = '0;
    model_deadline = '0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      slot_start[i] = '0;
      slot_delay[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    idle_pct = 29;
    test_empty_report();
    drain_results();
    test_fire_all_slots();
    drain_results();
    test_pull_in_and_wrap();
    drain_results();
    test_signed_extremes();
    drain_results();

    sim_cycle = $urandom();
    test_random_traffic(29, 160);
    drain_results();
    test_random_traffic(82, 160);
    drain_results();
    test_random_traffic(0, 160);
    drain_results();

    mismatches = mismatches + predicted_results.size();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
